FILE: design/shortest_path_counter_unit_assert.svh
// Assertion macros for the checker file of the shortest path counter.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef SHORTEST_PATH_COUNTER_UNIT_ASSERT_SVH
`define SHORTEST_PATH_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define SPC_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("spc: same-cycle check failed");

// next-cycle implication, off during reset
`define SPC_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("spc: next-cycle check failed");

// next-cycle implication, active during reset
`define SPC_ASSERT_RST(name, pre, post) \
   name: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("spc: reset check failed");

`endif

FILE: design/spc_pkg.sv
// Shared constants and types of the shortest path counter.
// No dependencies.
package spc_pkg;

   localparam int MAX_NODES    = 64;
   localparam int NODE_W       = $clog2(MAX_NODES);
   localparam int MAT_DEPTH    = MAX_NODES * MAX_NODES;
   localparam int MAT_AW       = 2 * NODE_W;
   localparam int NODE_FIELD_W = 6;
   localparam int CSR_W        = 7;
   localparam int WEIGHT_W     = 30;
   localparam int WAYS_W       = 30;
   localparam int DIST_W       = 40;
   localparam int OUT_DIST_W   = 36;

   localparam logic [CSR_W-1:0]  NODE_COUNT_RESET = CSR_W'(64);
   localparam logic [WAYS_W-1:0] PATH_MOD         = WAYS_W'(1000000007);

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [WAYS_W-1:0] ways;
   } node_word_type;

   typedef struct packed {
      logic              we;
      logic [MAT_AW-1:0] waddr;
      logic [WEIGHT_W-1:0] wdata;
      logic [MAT_AW-1:0] raddr;
   } mat_req_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      node_word_type     wdata;
      logic [NODE_W-1:0] raddr;
   } node_req_type;

endpackage

FILE: design/spc_channels.sv
// Valid/ready channels for the edge words and the result words.
// Depends on spc_pkg.
interface spc_req_if;
   import spc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [NODE_FIELD_W-1:0] node_a;
   logic [NODE_FIELD_W-1:0] node_b;
   logic [WEIGHT_W-1:0]     road_weight;
   logic                    edge_valid;
   logic                    last_edge;
   modport source (output valid, node_a, node_b, road_weight, edge_valid, last_edge,
                   input ready);
   modport sink (input valid, node_a, node_b, road_weight, edge_valid, last_edge,
                 output ready);
endinterface

interface spc_rsp_if;
   import spc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WAYS_W-1:0]     path_count;
   logic                  destination_reached;
   logic [OUT_DIST_W-1:0] shortest_distance;
   modport source (output valid, path_count, destination_reached, shortest_distance,
                   input ready);
   modport sink (input valid, path_count, destination_reached, shortest_distance,
                 output ready);
endinterface

FILE: design/spc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module spc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

FILE: design/spc_engine.sv
// Sequencer of the shortest path counter: edge loading, Dijkstra passes over the
// matrix RAM with a two-stage relax pipeline, result register and row clearing.
// Depends on spc_pkg and spc_channels.
module spc_engine (
   input  logic                       clock,
   input  logic                       reset,
   spc_req_if.sink                    req,
   spc_rsp_if.source                  rsp,
   input  logic [spc_pkg::NODE_W-1:0] last_node,
   output spc_pkg::mat_req_type       mat_req,
   input  logic [spc_pkg::WEIGHT_W-1:0] mat_rdata,
   output spc_pkg::node_req_type      node_req,
   input  spc_pkg::node_word_type     node_rdata
);
   import spc_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EDGE2  = 3'd2;
   localparam logic [2:0] ST_INIT   = 3'd3;
   localparam logic [2:0] ST_RELAX  = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_FETCH  = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);

   logic [2:0]           state_ff, state_in;
   logic [NODE_W-1:0]    row_ff, row_in;
   logic [NODE_W-1:0]    col_ff, col_in;
   logic [MAX_NODES-1:0] dirty_ff, dirty_in;
   logic                 edge_last_ff, edge_last_in;
   logic [NODE_W-1:0]    edge_a_ff, edge_a_in;
   logic [NODE_W-1:0]    edge_b_ff, edge_b_in;
   logic [WEIGHT_W-1:0]  edge_w_ff, edge_w_in;

   logic [MAX_NODES-1:0] reached_ff, reached_in;
   logic [MAX_NODES-1:0] settled_ff, settled_in;
   logic [NODE_W-1:0]    u_ff, u_in;
   logic [DIST_W-1:0]    du_ff, du_in;
   logic [WAYS_W-1:0]    wu_ff, wu_in;
   logic [NODE_W-1:0]    idx_ff, idx_in;

   logic                 p1_valid_ff, p1_valid_in;
   logic [NODE_W-1:0]    p1_idx_ff, p1_idx_in;
   logic                 p2_valid_ff, p2_valid_in;
   logic [NODE_W-1:0]    p2_idx_ff, p2_idx_in;
   logic                 p2_take_ff, p2_take_in;
   logic                 p2_eq_ff, p2_eq_in;
   logic                 p2_live_ff, p2_live_in;
   logic                 p2_reach_ff, p2_reach_in;
   logic [DIST_W-1:0]    p2_dist_ff, p2_dist_in;
   logic [WAYS_W-1:0]    p2_ways_ff, p2_ways_in;
   logic [WAYS_W:0]      p2_sum_ff, p2_sum_in;

   logic                 min_valid_ff, min_valid_in;
   logic [NODE_W-1:0]    min_idx_ff, min_idx_in;
   logic [DIST_W-1:0]    min_dist_ff, min_dist_in;
   logic [WAYS_W-1:0]    min_ways_ff, min_ways_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WAYS_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                  rsp_reached_ff, rsp_reached_in;
   logic [OUT_DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic                 accept;
   logic                 in_range;
   logic [NODE_W-1:0]    req_a;
   logic [NODE_W-1:0]    req_b;
   logic                 cand1;
   logic [DIST_W-1:0]    nd1;
   logic                 take1;
   logic                 eq1;
   logic [WAYS_W-1:0]    sum_mod2;
   logic [WAYS_W-1:0]    new_ways2;
   logic                 min_upd2;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign req_a     = NODE_W'(req.node_a);
   assign req_b     = NODE_W'(req.node_b);
   assign in_range  = (32'(req.node_a) <= 32'(last_node)) &&
                      (32'(req.node_b) <= 32'(last_node));

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.path_count          = rsp_count_ff;
   assign rsp.destination_reached = rsp_reached_ff;
   assign rsp.shortest_distance   = rsp_dist_ff;

   // relax stage 1: weight and node word are back from the RAMs
   assign cand1 = (mat_rdata != '0) && (p1_idx_ff != u_ff) && !settled_ff[p1_idx_ff];
   assign nd1   = du_ff + DIST_W'(mat_rdata);
   assign take1 = cand1 && (!reached_ff[p1_idx_ff] || (nd1 < node_rdata.distance));
   assign eq1   = cand1 && reached_ff[p1_idx_ff] && (nd1 == node_rdata.distance);

   // relax stage 2: write back and track the next node to settle
   assign sum_mod2 = (p2_sum_ff >= (WAYS_W + 1)'(PATH_MOD)) ?
                     WAYS_W'(p2_sum_ff - (WAYS_W + 1)'(PATH_MOD)) : WAYS_W'(p2_sum_ff);
   assign new_ways2 = p2_take_ff ? wu_ff : (p2_eq_ff ? sum_mod2 : p2_ways_ff);
   assign min_upd2  = p2_valid_ff && p2_reach_ff && p2_live_ff &&
                      (!min_valid_ff || (p2_dist_ff < min_dist_ff));

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dirty_in     = dirty_ff;
      edge_last_in = edge_last_ff;
      edge_a_in    = edge_a_ff;
      edge_b_in    = edge_b_ff;
      edge_w_in    = edge_w_ff;
      reached_in   = reached_ff;
      settled_in   = settled_ff;
      u_in         = u_ff;
      du_in        = du_ff;
      wu_in        = wu_ff;
      idx_in       = idx_ff;
      min_valid_in = min_valid_ff;
      min_idx_in   = min_idx_ff;
      min_dist_in  = min_dist_ff;
      min_ways_in  = min_ways_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_count_in   = rsp_count_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_dist_in    = rsp_dist_ff;

      p1_valid_in = 1'b0;
      p1_idx_in   = idx_ff;
      p2_valid_in = p1_valid_ff;
      p2_idx_in   = p1_idx_ff;
      p2_take_in  = take1;
      p2_eq_in    = eq1;
      p2_live_in  = !settled_ff[p1_idx_ff];
      p2_reach_in = reached_ff[p1_idx_ff] || take1;
      p2_dist_in  = take1 ? nd1 : node_rdata.distance;
      p2_ways_in  = node_rdata.ways;
      p2_sum_in   = (WAYS_W + 1)'(node_rdata.ways) + (WAYS_W + 1)'(wu_ff);

      mat_req.we    = 1'b0;
      mat_req.waddr = {row_ff, col_ff};
      mat_req.wdata = '0;
      mat_req.raddr = {u_ff, idx_ff};

      node_req.we             = 1'b0;
      node_req.waddr          = p2_idx_ff;
      node_req.wdata.distance = p2_dist_ff;
      node_req.wdata.ways     = new_ways2;
      node_req.raddr          = idx_ff;

      if (p2_valid_ff) begin
         node_req.we = p2_take_ff || p2_eq_ff;
         if (p2_take_ff) begin
            reached_in[p2_idx_ff] = 1'b1;
         end
      end
      if (min_upd2) begin
         min_valid_in = 1'b1;
         min_idx_in   = p2_idx_ff;
         min_dist_in  = p2_dist_ff;
         min_ways_in  = new_ways2;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (dirty_ff[row_ff]) begin
               mat_req.we = 1'b1;
               col_in     = col_ff + 1'b1;
            end
            if (!dirty_ff[row_ff] || (col_ff == LAST_IDX)) begin
               dirty_in[row_ff] = 1'b0;
               col_in           = '0;
               row_in           = row_ff + 1'b1;
               if (row_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               edge_last_in = req.last_edge;
               edge_a_in    = req_a;
               edge_b_in    = req_b;
               edge_w_in    = req.road_weight;
               if (req.edge_valid && in_range) begin
                  mat_req.we      = 1'b1;
                  mat_req.waddr   = {req_a, req_b};
                  mat_req.wdata   = req.road_weight;
                  dirty_in[req_a] = 1'b1;
                  dirty_in[req_b] = 1'b1;
                  state_in        = ST_EDGE2;
               end else if (req.last_edge) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_EDGE2: begin
            mat_req.we    = 1'b1;
            mat_req.waddr = {edge_b_ff, edge_a_ff};
            mat_req.wdata = edge_w_ff;
            state_in      = edge_last_ff ? ST_INIT : ST_IDLE;
         end
         ST_INIT: begin
            node_req.we             = 1'b1;
            node_req.waddr          = '0;
            node_req.wdata.distance = '0;
            node_req.wdata.ways     = WAYS_W'(1);
            reached_in              = MAX_NODES'(1);
            settled_in              = MAX_NODES'(1);
            u_in                    = '0;
            du_in                   = '0;
            wu_in                   = WAYS_W'(1);
            min_valid_in            = 1'b0;
            idx_in                  = '0;
            state_in                = ST_RELAX;
         end
         ST_RELAX: begin
            p1_valid_in = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == last_node) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               if (min_valid_ff) begin
                  u_in                   = min_idx_ff;
                  du_in                  = min_dist_ff;
                  wu_in                  = min_ways_ff;
                  settled_in[min_idx_ff] = 1'b1;
                  min_valid_in           = 1'b0;
                  idx_in                 = '0;
                  state_in               = ST_RELAX;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            node_req.raddr = last_node;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            node_req.raddr = last_node;
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_reached_in = reached_ff[last_node];
               rsp_count_in   = reached_ff[last_node] ? node_rdata.ways : '0;
               rsp_dist_in    = reached_ff[last_node] ?
                                OUT_DIST_W'(node_rdata.distance) : '0;
               row_in         = '0;
               col_in         = '0;
               state_in       = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         dirty_ff     <= '1;
         edge_last_ff <= 1'b0;
         reached_ff   <= '0;
         settled_ff   <= '0;
         idx_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         min_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         dirty_ff     <= dirty_in;
         edge_last_ff <= edge_last_in;
         reached_ff   <= reached_in;
         settled_ff   <= settled_in;
         idx_ff       <= idx_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         min_valid_ff <= min_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_a_ff      <= edge_a_in;
      edge_b_ff      <= edge_b_in;
      edge_w_ff      <= edge_w_in;
      u_ff           <= u_in;
      du_ff          <= du_in;
      wu_ff          <= wu_in;
      p1_idx_ff      <= p1_idx_in;
      p2_idx_ff      <= p2_idx_in;
      p2_take_ff     <= p2_take_in;
      p2_eq_ff       <= p2_eq_in;
      p2_live_ff     <= p2_live_in;
      p2_reach_ff    <= p2_reach_in;
      p2_dist_ff     <= p2_dist_in;
      p2_ways_ff     <= p2_ways_in;
      p2_sum_ff      <= p2_sum_in;
      min_idx_ff     <= min_idx_in;
      min_dist_ff    <= min_dist_in;
      min_ways_ff    <= min_ways_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

endmodule

FILE: design/shortest_path_counter_unit.sv
// Shortest path counter top level: node count register, matrix RAM, node RAM, engine.
// An edge word with a stored edge writes both matrix entries, the second in ST_EDGE2.
// A last word starts the Dijkstra passes, one per settled node over all active nodes,
// then the result, then a sweep to zero of each matrix row written since the last clear.
// Synchronous reset sets node_count to 64 and sweeps all 4096 matrix entries to zero
// before the first word is taken; configuration is taken at any time.
module shortest_path_counter_unit (
   input  logic                      clock,
   input  logic                      reset,
   spc_req_if.sink                   req_bus,
   spc_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [spc_pkg::CSR_W-1:0] csr_write_data
);
   import spc_pkg::*;

   logic [CSR_W-1:0]    node_count_ff, node_count_in;
   logic [NODE_W-1:0]   last_node;
   mat_req_type         mat_req;
   logic [WEIGHT_W-1:0] mat_rdata;
   node_req_type        node_req;
   node_word_type       node_rdata;

   always_comb begin
      node_count_in = csr_write_enable ? csr_write_data : node_count_ff;
      priority if (node_count_ff == '0) begin
         last_node = '0;
      end else if (32'(node_count_ff) > MAX_NODES) begin
         last_node = NODE_W'(MAX_NODES - 1);
      end else begin
         last_node = NODE_W'(node_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   spc_ram #(
      .DEPTH (MAT_DEPTH),
      .WIDTH (WEIGHT_W)
   ) u_matrix_ram (
      .clock (clock),
      .we    (mat_req.we),
      .waddr (mat_req.waddr),
      .wdata (mat_req.wdata),
      .raddr (mat_req.raddr),
      .rdata (mat_rdata)
   );

   spc_ram #(
      .DEPTH (MAX_NODES),
      .WIDTH ($bits(node_word_type))
   ) u_node_ram (
      .clock (clock),
      .we    (node_req.we),
      .waddr (node_req.waddr),
      .wdata (node_req.wdata),
      .raddr (node_req.raddr),
      .rdata (node_rdata)
   );

   spc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .last_node  (last_node),
      .mat_req    (mat_req),
      .mat_rdata  (mat_rdata),
      .node_req   (node_req),
      .node_rdata (node_rdata)
   );

endmodule

FILE: design/spc_checker.sv
// Port-level checks of the shortest path counter, bound to the top level.
// Depends on spc_pkg and shortest_path_counter_unit_assert.svh.
`include "shortest_path_counter_unit_assert.svh"

module spc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [spc_pkg::WAYS_W-1:0]     path_count,
   input logic                           destination_reached,
   input logic [spc_pkg::OUT_DIST_W-1:0] shortest_distance
);
   import spc_pkg::*;

   `SPC_ASSERT_RST(a_no_ready_after_reset, reset, !req_ready)
   `SPC_ASSERT_NXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)
   `SPC_ASSERT_IMP(a_unreached_zero, rsp_valid && !destination_reached, (path_count == '0) && (shortest_distance == '0))
   `SPC_ASSERT_IMP(a_reached_count, rsp_valid && destination_reached, (path_count != '0) && (path_count < PATH_MOD))

endmodule

bind shortest_path_counter_unit spc_checker u_spc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .path_count          (rsp_bus.path_count),
   .destination_reached (rsp_bus.destination_reached),
   .shortest_distance   (rsp_bus.shortest_distance)
);

FILE: bench/tb_top.sv
// Testbench for shortest_path_counter_unit: queues edge words, predicts every result word
// with its own Dijkstra sweep over a copy of the weight matrix, and checks results in order.
// Depends on spc_pkg, the channel interfaces in spc_channels.sv and the design files.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spc_pkg::*;

   localparam longint WAYS_MOD      = 1000000007;
   localparam int     SETTLE_CYCLES = 4500;
   localparam int     CYCLE_LIMIT   = 2000000;
   localparam int     RANDOM_WORDS  = 500;
   localparam int     MAX_GAP       = 11;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] node_a;
      logic [NODE_FIELD_W-1:0] node_b;
      logic [WEIGHT_W-1:0]     road_weight;
      logic                    edge_valid;
      logic                    last_edge;
   } road_word_type;

   typedef struct packed {
      logic [WAYS_W-1:0]     path_count;
      logic                  destination_reached;
      logic [OUT_DIST_W-1:0] shortest_distance;
   } path_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   spc_req_if req_bus ();
   spc_rsp_if rsp_bus ();

   road_word_type       road_words_due[$];
   path_result_type     paths_due[$];
   logic [WEIGHT_W-1:0] road_len [MAX_NODES][MAX_NODES];
   logic [CSR_W-1:0]    node_limit;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;
   int                  words_queued   = 0;
   logic                req_taken      = 1'b0;
   logic                rsp_taken      = 1'b0;
   int                  req_gap        = 0;
   int                  rsp_wait       = 0;
   bit                  req_idle_en    = 1'b1;
   bit                  rsp_idle_en    = 1'b1;

   shortest_path_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_nodes(input logic [CSR_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > MAX_NODES) return MAX_NODES;
      return int'(setting);
   endfunction

   function automatic int unsigned road_weight_draw();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return 0;
      if (pick < 65) return $urandom_range(1, 4);
      if (pick < 85) return $urandom_range(1, 1000);
      return $urandom_range(1, 1000000000);
   endfunction

   function automatic path_result_type solve_paths(input int n);
      logic [DIST_W-1:0] best_len [MAX_NODES];
      longint            ways [MAX_NODES];
      bit                reached [MAX_NODES];
      bit                settled [MAX_NODES];
      logic [DIST_W-1:0] nd;
      path_result_type   res;
      int                u;
      foreach (reached[i]) begin
         reached[i]  = 1'b0;
         settled[i]  = 1'b0;
         best_len[i] = '0;
         ways[i]     = 0;
      end
      reached[0] = 1'b1;
      ways[0]    = 1;
      for (int step = 0; step < n; step++) begin
         u = n;
         for (int i = 0; i < n; i++) begin
            if (reached[i] && !settled[i] && (u == n || best_len[i] < best_len[u])) u = i;
         end
         if (u == n) break;
         settled[u] = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (road_len[u][i] != 0 && i != u && !settled[i]) begin
               nd = best_len[u] + DIST_W'(road_len[u][i]);
               if (!reached[i] || nd < best_len[i]) begin
                  reached[i]  = 1'b1;
                  best_len[i] = nd;
                  ways[i]     = ways[u];
               end else if (nd == best_len[i]) begin
                  ways[i] = (ways[i] + ways[u]) % WAYS_MOD;
               end
            end
         end
      end
      res = '0;
      if (reached[n-1]) begin
         res.path_count          = ways[n-1][WAYS_W-1:0];
         res.destination_reached = 1'b1;
         res.shortest_distance   = best_len[n-1][OUT_DIST_W-1:0];
      end
      return res;
   endfunction

   task automatic queue_word(input int a, input int b, input int unsigned w,
                             input bit ev, input bit last);
      road_word_type word;
      word.node_a      = NODE_FIELD_W'(a);
      word.node_b      = NODE_FIELD_W'(b);
      word.road_weight = WEIGHT_W'(w);
      word.edge_valid  = ev;
      word.last_edge   = last;
      road_words_due   = {road_words_due, word};
      if (ev || last) words_queued++;
   endtask

   task automatic write_node_count(input logic [CSR_W-1:0] setting);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle_idle();
      while (road_words_due.size() != 0 || req_bus.valid || paths_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // edge word driver
   always @(negedge clock) begin
      road_word_type word;
      if (!(req_bus.valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (road_words_due.size() > 0) begin
            word = road_words_due.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.node_a      <= word.node_a;
            req_bus.node_b      <= word.node_b;
            req_bus.road_weight <= word.road_weight;
            req_bus.edge_valid  <= word.edge_valid;
            req_bus.last_edge   <= word.last_edge;
            req_gap             <= req_idle_en ? $urandom_range(0, MAX_GAP) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result word stall
   always @(negedge clock) begin
      int stall;
      if (rsp_taken) begin
         stall = rsp_idle_en ? $urandom_range(0, MAX_GAP) : 0;
         rsp_bus.ready <= (stall == 0);
         rsp_wait      <= (stall == 0) ? 0 : stall - 1;
      end else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= rsp_wait - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // predict on accepted edge words, check accepted result words
   always @(posedge clock) begin
      path_result_type got;
      path_result_type want;
      int              n;
      if (reset) begin
         req_taken  <= 1'b0;
         rsp_taken  <= 1'b0;
         node_limit = NODE_COUNT_RESET;
         foreach (road_len[i, j]) road_len[i][j] = '0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         rsp_taken <= rsp_bus.valid && rsp_bus.ready;
         if (csr_write_enable) node_limit = csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            n = active_nodes(node_limit);
            if (req_bus.edge_valid && req_bus.node_a < n && req_bus.node_b < n) begin
               road_len[req_bus.node_a][req_bus.node_b] = req_bus.road_weight;
               road_len[req_bus.node_b][req_bus.node_a] = req_bus.road_weight;
            end
            if (req_bus.last_edge) begin
               paths_due = {paths_due, solve_paths(n)};
               foreach (road_len[i, j]) road_len[i][j] = '0;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.path_count          = rsp_bus.path_count;
            got.destination_reached = rsp_bus.destination_reached;
            got.shortest_distance   = rsp_bus.shortest_distance;
            if (paths_due.size() == 0) begin
               $display("%0t: result word expected none, got count %0d reached %0b distance %0d",
                        $time, got.path_count, got.destination_reached, got.shortest_distance);
               mismatch_count++;
            end else begin
               want = paths_due.pop_front();
               if (got.path_count !== want.path_count) begin
                  $display("%0t: path_count expected %0d got %0d",
                           $time, want.path_count, got.path_count);
                  mismatch_count++;
               end
               if (got.destination_reached !== want.destination_reached) begin
                  $display("%0t: destination_reached expected %0b got %0b",
                           $time, want.destination_reached, got.destination_reached);
                  mismatch_count++;
               end
               if (got.shortest_distance !== want.shortest_distance) begin
                  $display("%0t: shortest_distance expected %0d got %0d",
                           $time, want.shortest_distance, got.shortest_distance);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int               n;
      int               edges;
      int               walker;
      int               hop;
      int               pick;
      int               target;
      logic [CSR_W-1:0] setting;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.node_a      = '0;
      req_bus.node_b      = '0;
      req_bus.road_weight = '0;
      req_bus.edge_valid  = 1'b0;
      req_bus.last_edge   = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two equal shortest paths, edge carried on the last word
      write_node_count(7'd4);
      queue_word(0, 1, 1, 1'b1, 1'b0);
      queue_word(1, 3, 2, 1'b1, 1'b0);
      queue_word(0, 2, 2, 1'b1, 1'b0);
      queue_word(2, 3, 1, 1'b1, 1'b1);
      // erased road, self road, unreachable destination, bare end marker
      queue_word(0, 1, 5, 1'b1, 1'b0);
      queue_word(1, 3, 5, 1'b1, 1'b0);
      queue_word(1, 3, 0, 1'b1, 1'b0);
      queue_word(3, 3, 7, 1'b1, 1'b0);
      queue_word(2, 3, 5, 1'b1, 1'b0);
      queue_word(63, 63, 30'h3FFFFFFF, 1'b0, 1'b1);
      settle_idle();
      // single node, out-of-range road
      write_node_count(7'd1);
      queue_word(0, 5, 9, 1'b1, 1'b0);
      queue_word(42, 21, 30'h15555555, 1'b0, 1'b1);
      settle_idle();
      write_node_count(7'd0);
      queue_word(0, 0, 3, 1'b1, 1'b1);
      settle_idle();
      // count above the maximum, heaviest roads
      write_node_count(7'd127);
      queue_word(0, 63, 1000000000, 1'b1, 1'b0);
      queue_word(0, 62, 1000000000, 1'b1, 1'b0);
      queue_word(62, 63, 1, 1'b1, 1'b1);
      settle_idle();
      // shrink the node count in the middle of a graph
      write_node_count(7'd64);
      queue_word(0, 40, 7, 1'b1, 1'b0);
      queue_word(40, 63, 7, 1'b1, 1'b0);
      settle_idle();
      write_node_count(7'd8);
      queue_word(40, 7, 1, 1'b1, 1'b0);
      queue_word(0, 0, 0, 1'b0, 1'b0);
      queue_word(0, 7, 100, 1'b1, 1'b1);
      settle_idle();

      target = words_queued + RANDOM_WORDS;
      while (words_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) setting = CSR_W'($urandom_range(2, 8));
         else if (pick < 80) setting = CSR_W'($urandom_range(9, 20));
         else if (pick < 92) setting = CSR_W'($urandom_range(21, 64));
         else if (pick < 96) setting = CSR_W'($urandom_range(0, 1));
         else setting = CSR_W'($urandom_range(65, 127));
         n = active_nodes(setting);
         req_idle_en = ($urandom_range(0, 3) != 0);
         rsp_idle_en = ($urandom_range(0, 3) != 0);
         write_node_count(setting);
         repeat ($urandom_range(1, 3)) begin
            walker = 0;
            edges  = $urandom_range(0, (n < 12) ? 2 * n : 24);
            repeat (edges) begin
               pick = $urandom_range(0, 99);
               if (pick < 5) begin
                  queue_word($urandom_range(0, 63), $urandom_range(0, 63), $urandom(),
                             1'b0, 1'b0);
               end else if (pick < 12) begin
                  queue_word($urandom_range(0, 63), $urandom_range(0, 63), road_weight_draw(),
                             1'b1, 1'b0);
               end else if (pick < 55) begin
                  hop = $urandom_range(0, n - 1);
                  queue_word(walker, hop, road_weight_draw(), 1'b1, 1'b0);
                  walker = hop;
               end else begin
                  queue_word($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                             road_weight_draw(), 1'b1, 1'b0);
               end
            end
            if ($urandom_range(0, 1)) begin
               queue_word(walker, n - 1, road_weight_draw(), 1'b1, 1'b1);
            end else begin
               queue_word($urandom_range(0, 63), $urandom_range(0, 63), $urandom(),
                          1'b0, 1'b1);
            end
         end
         settle_idle();
      end

      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
